### rtl/core/srr_pkg.sv
// Shared types and constants for the sprite row renderer.
// Holds opcodes, register indexes, clip bounds and the read tag struct.
// No dependencies.
`default_nettype none

package srr_pkg;

	localparam int ROM_BYTES_DEF = 65536;
	localparam int BG_BYTES      = 32768;
	localparam int BG_AW         = 15;
	localparam int ROW_PIXELS    = 8;
	localparam int STEP_W        = 3;

	localparam logic [7:0] Y_FLOOR = 8'd16;
	localparam logic [7:0] Y_CEIL  = 8'd240;
	localparam logic [7:0] Y_SHIFT = 8'd17;

	localparam int FLAG_VFLIP = 7;
	localparam int FLAG_HFLIP = 6;

	typedef enum logic [1:0] {
		OP_ROM_WR = 2'd0,
		OP_BG_WR  = 2'd1,
		OP_DRAW   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CFG_CLIP_LEFT   = 3'd0,
		CFG_CLIP_RIGHT  = 3'd1,
		CFG_CLIP_TOP    = 3'd2,
		CFG_CLIP_BOTTOM = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] right;
		logic [7:0] top;
		logic [7:0] bottom;
	} clip_t;

	// Travels with each memory read: where the pixel lands and how to pick nibbles.
	typedef struct packed {
		logic       lst;
		logic       ok;
		logic       rnib;
		logic       bnib;
		logic [7:0] x;
		logic [7:0] y;
		logic [1:0] bank;
	} tag_t;

endpackage

`default_nettype wire

### rtl/core/sprite_row_render_over_background_core.sv
// A draw item makes one sprite ROM and one background read per pixel, and the next item
// is accepted as the row's last read goes out; ROM and background write items do not
// occupy the read sequencer.
// Reset: asynchronous, clears control and clip registers (left 0, right 255, top 0,
// bottom 255); the sprite ROM and background memories are not cleared.
// Depends on srr_pkg, srr_seq, srr_ram, srr_pix.
`default_nettype none

module sprite_row_render_over_background_core #(
	parameter int ROM_BYTES = srr_pkg::ROM_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  write_byte,
	input  wire logic [7:0]  attr_flags,
	input  wire logic [7:0]  image_low,
	input  wire logic [7:0]  sprite_top,
	input  wire logic [7:0]  sprite_left,
	input  wire logic [3:0]  row_index,
	input  wire logic [1:0]  line_bank,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       pixel_x,
	output logic [7:0]       pixel_y,
	output logic [9:0]       pen_index,
	output logic             last_pixel
);

	localparam int RA = $clog2(ROM_BYTES);

	srr_pkg::clip_t clip_q;
	srr_pkg::tag_t  tag;
	logic           take;
	logic           issue;
	logic           rom_we;
	logic [RA-1:0]  rom_waddr;
	logic [7:0]     rom_wdata;
	logic [RA-1:0]  rom_raddr;
	logic [7:0]     rom_rdata;
	logic           bg_we;
	logic [srr_pkg::BG_AW-1:0] bg_waddr;
	logic [7:0]     bg_wdata;
	logic [srr_pkg::BG_AW-1:0] bg_raddr;
	logic [7:0]     bg_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= 8'd0;
			clip_q.right  <= 8'd255;
			clip_q.top    <= 8'd0;
			clip_q.bottom <= 8'd255;
		end else if (cfg_we) begin
			case (srr_pkg::cfg_idx_t'(cfg_index))
				srr_pkg::CFG_CLIP_LEFT:   clip_q.left   <= cfg_data;
				srr_pkg::CFG_CLIP_RIGHT:  clip_q.right  <= cfg_data;
				srr_pkg::CFG_CLIP_TOP:    clip_q.top    <= cfg_data;
				srr_pkg::CFG_CLIP_BOTTOM: clip_q.bottom <= cfg_data;
				default: ;
			endcase
		end
	end

	srr_seq #(
		.ROM_BYTES(ROM_BYTES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.address    (address),
		.write_byte (write_byte),
		.attr_flags (attr_flags),
		.image_low  (image_low),
		.sprite_top (sprite_top),
		.sprite_left(sprite_left),
		.row_index  (row_index),
		.line_bank  (line_bank),
		.clip       (clip_q),
		.take       (take),
		.issue      (issue),
		.tag        (tag),
		.rom_we     (rom_we),
		.rom_waddr  (rom_waddr),
		.rom_wdata  (rom_wdata),
		.rom_raddr  (rom_raddr),
		.bg_we      (bg_we),
		.bg_waddr   (bg_waddr),
		.bg_wdata   (bg_wdata),
		.bg_raddr   (bg_raddr)
	);

	srr_ram #(
		.W    (8),
		.DEPTH(ROM_BYTES)
	) u_rom (
		.clk  (clk),
		.we   (rom_we),
		.waddr(rom_waddr),
		.wdata(rom_wdata),
		.re   (issue),
		.raddr(rom_raddr),
		.rdata(rom_rdata)
	);

	// Background held as bytes: two pixels per entry, high nibble first.
	srr_ram #(
		.W    (8),
		.DEPTH(srr_pkg::BG_BYTES)
	) u_bg (
		.clk  (clk),
		.we   (bg_we),
		.waddr(bg_waddr),
		.wdata(bg_wdata),
		.re   (issue),
		.raddr(bg_raddr),
		.rdata(bg_rdata)
	);

	srr_pix u_pix (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (issue),
		.tag       (tag),
		.rom_rdata (rom_rdata),
		.bg_rdata  (bg_rdata),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.pen_index (pen_index),
		.last_pixel(last_pixel)
	);

endmodule

`default_nettype wire

### rtl/core/srr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old contents when it meets a write to the same entry.
// No dependencies.
`default_nettype none

module srr_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/core/srr_seq.sv
// Item intake and read sequencer: drives memory writes, steps a draw over eight pixels.
// Depends on srr_pkg.
`default_nettype none

module srr_seq #(
	parameter int ROM_BYTES = srr_pkg::ROM_BYTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   opcode,
	input  wire logic [15:0]                  address,
	input  wire logic [7:0]                   write_byte,
	input  wire logic [7:0]                   attr_flags,
	input  wire logic [7:0]                   image_low,
	input  wire logic [7:0]                   sprite_top,
	input  wire logic [7:0]                   sprite_left,
	input  wire logic [3:0]                   row_index,
	input  wire logic [1:0]                   line_bank,
	input  wire srr_pkg::clip_t               clip,
	input  wire logic                         take,
	output logic                              issue,
	output srr_pkg::tag_t                     tag,
	output logic                              rom_we,
	output logic [$clog2(ROM_BYTES)-1:0]      rom_waddr,
	output logic [7:0]                        rom_wdata,
	output logic [$clog2(ROM_BYTES)-1:0]      rom_raddr,
	output logic                              bg_we,
	output logic [srr_pkg::BG_AW-1:0]         bg_waddr,
	output logic [7:0]                        bg_wdata,
	output logic [srr_pkg::BG_AW-1:0]         bg_raddr
);

	localparam int RA = $clog2(ROM_BYTES);
	localparam int WA = (RA > 16) ? RA : 16;

	logic                       busy_q;
	logic [srr_pkg::STEP_W-1:0] step_q;
	logic [10:0]                img_q;
	logic [3:0]                 rsel_q;
	logic                       hflip_q;
	logic [7:0]                 left_q;
	logic [7:0]                 y_q;
	logic                       yok_q;
	logic [1:0]                 bank_q;

	logic                       accept;
	logic                       is_draw;
	logic                       last_step;
	logic [7:0]                 y_new;
	logic [7:0]                 y_min;
	logic [7:0]                 y_max;
	logic [srr_pkg::STEP_W-1:0] src;
	logic [16:0]                rom_full;
	logic [8:0]                 x_sum;
	logic                       x_in;
	logic [15:0]                bg_idx;
	logic [WA-1:0]              addr_ext;

	assign accept    = in_valid && in_ready;
	assign is_draw   = srr_pkg::op_t'(opcode) == srr_pkg::OP_DRAW;
	assign last_step = step_q == srr_pkg::STEP_W'(srr_pkg::ROW_PIXELS - 1);
	assign issue     = busy_q && take;
	// Next item may enter while the final read of this row goes out.
	assign in_ready  = !busy_q || (issue && last_step);

	assign y_new = sprite_top + srr_pkg::Y_SHIFT + {4'd0, row_index};
	assign y_min = (clip.top < srr_pkg::Y_FLOOR) ? srr_pkg::Y_FLOOR : clip.top;
	assign y_max = (clip.bottom > srr_pkg::Y_CEIL) ? srr_pkg::Y_CEIL : clip.bottom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept && is_draw) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (issue) begin
			step_q <= step_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_draw) begin
			img_q   <= {attr_flags[2:0], image_low};
			rsel_q  <= attr_flags[srr_pkg::FLAG_VFLIP] ? ~row_index : row_index;
			hflip_q <= attr_flags[srr_pkg::FLAG_HFLIP];
			left_q  <= sprite_left;
			y_q     <= y_new;
			yok_q   <= (y_new >= y_min) && (y_new <= y_max);
			bank_q  <= line_bank;
		end
	end

	// Source pixel in the row: reversed under horizontal flip.
	assign src      = hflip_q ? ~step_q : step_q;
	assign rom_full = {img_q, rsel_q, src[2:1]};
	assign rom_raddr = rom_full[RA-1:0];

	assign x_sum  = {1'b0, left_q} + {6'd0, step_q};
	assign x_in   = !x_sum[8] && (x_sum[7:0] >= clip.left) && (x_sum[7:0] <= clip.right);
	assign bg_idx = 16'({y_q, 8'h00} + {7'd0, x_sum});
	assign bg_raddr = bg_idx[15:1];

	always_comb begin
		tag.lst  = last_step;
		tag.ok   = yok_q && x_in;
		tag.rnib = src[0];
		tag.bnib = bg_idx[0];
		tag.x    = x_sum[7:0];
		tag.y    = y_q;
		tag.bank = bank_q;
	end

	assign addr_ext  = WA'(address);
	assign rom_we    = accept && (srr_pkg::op_t'(opcode) == srr_pkg::OP_ROM_WR);
	assign rom_waddr = addr_ext[RA-1:0];
	assign rom_wdata = write_byte;
	assign bg_we     = accept && (srr_pkg::op_t'(opcode) == srr_pkg::OP_BG_WR);
	assign bg_waddr  = address[srr_pkg::BG_AW-1:0];
	assign bg_wdata  = write_byte;

endmodule

`default_nettype wire

### rtl/core/srr_pix.sv
// Pixel stage: takes memory read data, drops transparent or clipped pixels,
// holds one pixel back to mark the row's last, feeds the output register. Uses srr_pkg.
`default_nettype none

module srr_pix (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          issue,
	input  wire srr_pkg::tag_t tag,
	input  wire logic [7:0]    rom_rdata,
	input  wire logic [7:0]    bg_rdata,
	output logic               take,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [7:0]         pixel_x,
	output logic [7:0]         pixel_y,
	output logic [9:0]         pen_index,
	output logic               last_pixel
);

	logic          s1_valid_q;
	srr_pkg::tag_t tag_s1;
	logic          pend_valid_q;
	logic          pend_last_q;
	logic [7:0]    pend_x_q;
	logic [7:0]    pend_y_q;
	logic [9:0]    pend_pen_q;
	logic          out_valid_q;

	logic [3:0]    spr;
	logic [3:0]    bgn;
	logic          drawn;
	logic          s1_lst;
	logic          out_free;
	logic          pend_go;
	logic          s1_adv;

	assign spr    = tag_s1.rnib ? rom_rdata[3:0] : rom_rdata[7:4];
	assign bgn    = tag_s1.bnib ? bg_rdata[3:0] : bg_rdata[7:4];
	assign drawn  = s1_valid_q && tag_s1.ok && (spr != 4'd0);
	assign s1_lst = s1_valid_q && tag_s1.lst;

	assign out_free = !out_valid_q || out_ready;
	// Release the held pixel once a later one shows up or its row has ended.
	assign pend_go  = pend_valid_q && out_free && (pend_last_q || drawn || s1_lst);
	assign s1_adv   = s1_valid_q && (!drawn || !pend_valid_q || pend_go);
	assign take     = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take) begin
			s1_valid_q <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (take && issue) begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_last_q  <= 1'b0;
		end else if (s1_adv && drawn) begin
			pend_valid_q <= 1'b1;
			pend_last_q  <= tag_s1.lst;
		end else if (pend_go) begin
			pend_valid_q <= 1'b0;
		end else if (s1_lst && !drawn && pend_valid_q) begin
			// Row ended with nothing more drawn while output is stalled: mark held pixel.
			pend_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && drawn) begin
			pend_x_q   <= tag_s1.x;
			pend_y_q   <= tag_s1.y;
			pend_pen_q <= {tag_s1.bank, spr, bgn};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_go) begin
			pixel_x    <= pend_x_q;
			pixel_y    <= pend_y_q;
			pen_index  <= pend_pen_q;
			last_pixel <= pend_last_q || (s1_lst && !drawn);
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### rtl/core/srr_chk.sv
// Port-level checker for the sprite row renderer, bound to the top level.
// Depends on srr_pkg and sprite_row_render_over_background_core.
`default_nettype none

module srr_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  opcode,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [7:0]  pixel_x,
	input wire logic [7:0]  pixel_y,
	input wire logic [9:0]  pen_index,
	input wire logic        last_pixel
);

	// Stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(pen_index) && $stable(last_pixel))
		else $error("stalled result changed");

	// Transparent sprite pixels never come out.
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pen_index[7:4] != 4'd0)
		else $error("result with zero sprite nibble");

	// Lines outside the fixed vertical window are never drawn.
	a_y_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pixel_y >= srr_pkg::Y_FLOOR && pixel_y <= srr_pkg::Y_CEIL)
		else $error("result outside vertical window");

	// A draw item keeps the read sequencer busy, so input is not taken right after it.
	a_draw_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == srr_pkg::OP_DRAW |=> !in_ready)
		else $error("input taken right after a draw item");

endmodule

bind sprite_row_render_over_background_core srr_chk u_srr_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.opcode    (opcode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pixel_x   (pixel_x),
	.pixel_y   (pixel_y),
	.pen_index (pen_index),
	.last_pixel(last_pixel)
);

`default_nettype wire
